/* sv/power_cap_thread_dvfs_search_top_assert.svh */
// ----------------------------------------------------------------------------
// power cap thread/dvfs search assertion macros
// shared concurrent assertion forms, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef POWER_CAP_THREAD_DVFS_SEARCH_TOP_ASSERT_SVH
`define POWER_CAP_THREAD_DVFS_SEARCH_TOP_ASSERT_SVH

// property that must hold at every edge out of reset
`define PCTDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pctds assertion failed");

// consequent must hold in the cycle after the antecedent
`define PCTDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pctds assertion failed");

`endif

/* sv/pctds_pkg.sv */
// ----------------------------------------------------------------------------
// pctds_pkg
// widths, reset values, codes and clamp helpers of the power cap search
// ----------------------------------------------------------------------------
package pctds_pkg;

  localparam int MaxThreads  = 64;
  localparam int PstateCount = 16;

  localparam int ThrW  = 7;
  localparam int PstW  = 4;
  localparam int DataW = 32;
  localparam int CfgIdxW = 3;

  // config register reset values
  localparam logic [DataW-1:0] PowerLimitRst    = DataW'(100000);
  localparam logic [ThrW-1:0]  TotalThreadsRst  = ThrW'(64);
  localparam logic [PstW-1:0]  SlowestPstateRst = PstW'(15);
  localparam logic [ThrW-1:0]  StartThreadsRst  = ThrW'(1);
  localparam logic [PstW-1:0]  StartPstateRst   = PstW'(15);

  localparam logic [1:0] StepSat = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_LIMIT    = 3'd0,
    CFG_TOTAL_THREADS  = 3'd1,
    CFG_SLOWEST_PSTATE = 3'd2,
    CFG_START_THREADS  = 3'd3,
    CFG_START_PSTATE   = 3'd4
  } cfg_idx_e;

  // search phase, one-hot
  typedef enum logic [2:0] {
    PH_TUNE   = 3'b001,
    PH_FASTER = 3'b010,
    PH_SLOWER = 3'b100
  } phase_e;

  // effective thread limit in [1, MaxThreads]
  function automatic logic [ThrW-1:0] lim_threads(input logic [ThrW-1:0] total);
    logic [ThrW-1:0] r;
    r = total;
    if (total == '0) r = ThrW'(1);
    else if (total > ThrW'(MaxThreads)) r = ThrW'(MaxThreads);
    return r;
  endfunction

  // effective slowest p-state in [1, PstateCount-1]
  function automatic logic [PstW-1:0] lim_pstate(input logic [PstW-1:0] slowest);
    logic [PstW-1:0] r;
    r = slowest;
    if (slowest == '0) r = PstW'(1);
    else if ({1'b0, slowest} > (PstW+1)'(PstateCount - 1)) r = PstW'(PstateCount - 1);
    return r;
  endfunction

  // clamp a thread count candidate to [1, hi]
  function automatic logic [ThrW-1:0] clamp_thr(input logic [ThrW:0] v,
                                                input logic [ThrW-1:0] hi);
    logic [ThrW-1:0] r;
    r = v[ThrW-1:0];
    if (v == '0) r = ThrW'(1);
    else if (v > {1'b0, hi}) r = hi;
    return r;
  endfunction

  // clamp a p-state candidate to [0, hi]
  function automatic logic [PstW-1:0] clamp_pst(input logic [PstW:0] v,
                                                input logic [PstW-1:0] hi);
    logic [PstW-1:0] r;
    r = v[PstW-1:0];
    if (v > {1'b0, hi}) r = hi;
    return r;
  endfunction

endpackage

/* sv/power_cap_thread_dvfs_search_top.sv */
// ----------------------------------------------------------------------------
// power_cap_thread_dvfs_search_top
// thread count and p-state search under a power cap, one interval per item
// ----------------------------------------------------------------------------
// Each input item is one measurement interval (throughput and power at the
// configuration now applied, or a restart request); each item yields exactly
// one result item with the thread count and p-state for the next interval and
// a done flag. The block takes one item per clock cycle while the result is
// taken: an accepted item is caught in the input register, and once the
// result slot is free the whole search step (cap compares, the nine-tenths
// throughput test, phase decisions and clamping) runs as one combinational
// pass and lands in the search state registers, which drive the result
// directly. The result is valid in the cycle after that step; the rate is
// set by that update of the search state, which the next item needs. While a
// result waits on out_ready_i the input register holds one more item, and
// in_ready_o then stays low until the result is taken. Configuration writes
// are always accepted and must only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module power_cap_thread_dvfs_search_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pctds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pctds_pkg::DataW-1:0]     cfg_data_i,
  // measurement item channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  input  logic [pctds_pkg::DataW-1:0]     throughput_i,
  input  logic [pctds_pkg::DataW-1:0]     power_i,
  // result item channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pctds_pkg::ThrW-1:0]      next_threads_o,
  output logic [pctds_pkg::PstW-1:0]      next_pstate_o,
  output logic                            search_done_o
);

  localparam int ThrW  = pctds_pkg::ThrW;
  localparam int PstW  = pctds_pkg::PstW;
  localparam int DataW = pctds_pkg::DataW;
  localparam int ProdW = DataW + 4;

  // configuration registers
  logic [DataW-1:0] power_limit_q;
  logic [ThrW-1:0]  total_thr_q;
  logic [PstW-1:0]  slowest_pst_q;
  logic [ThrW-1:0]  start_thr_q;
  logic [PstW-1:0]  start_pst_q;

  // input register
  logic             in_vld_q, in_vld_d;
  logic             restart_q;
  logic [DataW-1:0] tput_q;
  logic [DataW-1:0] power_q;

  // result valid
  logic             out_vld_q, out_vld_d;
  logic             advance;

  // search state
  pctds_pkg::phase_e phase_q, phase_d;
  logic [1:0]       step_q, step_d;
  logic             going_down_q, going_down_d;
  logic             stopped_q, stopped_d;
  logic [ThrW-1:0]  cur_thr_q, cur_thr_d;
  logic [PstW-1:0]  cur_pst_q, cur_pst_d;
  logic             best_vld_q, best_vld_d;
  logic [DataW-1:0] best_tput_q, best_tput_d;
  logic [ThrW-1:0]  best_thr_q, best_thr_d;
  logic [PstW-1:0]  best_pst_q, best_pst_d;
  logic [DataW-1:0] level_tput_q, level_tput_d;
  logic [ThrW-1:0]  p0_thr_q, p0_thr_d;
  logic [PstW-1:0]  p0_pst_q, p0_pst_d;

  // step decode helpers
  logic [ThrW-1:0]  tt;
  logic [PstW-1:0]  sp;
  logic             under, over;
  logic [ProdW-1:0] tput_x10, best_x9;
  logic             below, best_pos;
  logic             do_leave0, do_leave1, do_finish;
  logic [ThrW:0]    thr_up, thr_dn;

  // --------------------------------------------------------------------------
  // configuration port, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_limit_q <= pctds_pkg::PowerLimitRst;
      total_thr_q   <= pctds_pkg::TotalThreadsRst;
      slowest_pst_q <= pctds_pkg::SlowestPstateRst;
      start_thr_q   <= pctds_pkg::StartThreadsRst;
      start_pst_q   <= pctds_pkg::StartPstateRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pctds_pkg::CFG_POWER_LIMIT:    power_limit_q <= cfg_data_i;
        pctds_pkg::CFG_TOTAL_THREADS:  total_thr_q   <= cfg_data_i[ThrW-1:0];
        pctds_pkg::CFG_SLOWEST_PSTATE: slowest_pst_q <= cfg_data_i[PstW-1:0];
        pctds_pkg::CFG_START_THREADS:  start_thr_q   <= cfg_data_i[ThrW-1:0];
        pctds_pkg::CFG_START_PSTATE:   start_pst_q   <= cfg_data_i[PstW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input register feeds the search step when the result slot
  // is free or being emptied this cycle
  // --------------------------------------------------------------------------
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_ready_o ? in_valid_i : in_vld_q;
    if (advance) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      restart_q <= restart_i;
      tput_q    <= throughput_i;
      power_q   <= power_i;
    end
  end

  // --------------------------------------------------------------------------
  // search step
  // --------------------------------------------------------------------------
  assign tt       = pctds_pkg::lim_threads(total_thr_q);
  assign sp       = pctds_pkg::lim_pstate(slowest_pst_q);
  assign under    = power_q < power_limit_q;  // equal to the cap is neither
  assign over     = power_q > power_limit_q;
  assign tput_x10 = ({4'b0, tput_q} << 3) + ({4'b0, tput_q} << 1);
  assign thr_up   = {1'b0, cur_thr_q} + (ThrW+1)'(1);
  assign thr_dn   = {1'b0, cur_thr_q} - (ThrW+1)'(1);

  always_comb begin
    phase_d      = phase_q;
    step_d       = step_q;
    going_down_d = going_down_q;
    stopped_d    = stopped_q;
    cur_thr_d    = cur_thr_q;
    cur_pst_d    = cur_pst_q;
    best_vld_d   = best_vld_q;
    best_tput_d  = best_tput_q;
    best_thr_d   = best_thr_q;
    best_pst_d   = best_pst_q;
    level_tput_d = level_tput_q;
    p0_thr_d     = p0_thr_q;
    p0_pst_d     = p0_pst_q;
    do_leave0    = 1'b0;
    do_leave1    = 1'b0;
    do_finish    = 1'b0;
    best_x9      = '0;
    below        = 1'b0;
    best_pos     = 1'b0;

    if (advance) begin
      if (restart_q) begin
        phase_d      = pctds_pkg::PH_TUNE;
        step_d       = '0;
        going_down_d = 1'b0;
        stopped_d    = 1'b0;
        best_vld_d   = 1'b0;
        best_tput_d  = '0;
        best_thr_d   = '0;
        best_pst_d   = '0;
        level_tput_d = '0;
        p0_thr_d     = '0;
        p0_pst_d     = '0;
        cur_thr_d    = pctds_pkg::clamp_thr({1'b0, start_thr_q}, tt);
        cur_pst_d    = pctds_pkg::clamp_pst({1'b0, start_pst_q}, sp);
      end else if (!stopped_q) begin
        // best under-cap configuration, against the applied one
        if (under && (!best_vld_q || tput_q > best_tput_q ||
                      (best_thr_q == cur_thr_q && cur_pst_q <= best_pst_q))) begin
          best_vld_d  = 1'b1;
          best_tput_d = tput_q;
          best_thr_d  = cur_thr_q;
          best_pst_d  = cur_pst_q;
        end
        // drop test: 10*t < 9*best, against the updated best
        best_x9  = ({4'b0, best_tput_d} << 3) + {4'b0, best_tput_d};
        below    = best_vld_d && (tput_x10 < best_x9);
        best_pos = best_vld_d && (best_tput_d != '0);

        unique case (phase_q)
          pctds_pkg::PH_TUNE: begin
            if (step_q == '0) begin
              if (cur_thr_q != tt && under) begin
                cur_thr_d = pctds_pkg::clamp_thr(thr_up, tt);
              end else if (cur_thr_q > ThrW'(1)) begin
                going_down_d = 1'b1;
                cur_thr_d    = pctds_pkg::clamp_thr(thr_dn, tt);
              end else begin
                do_leave0 = 1'b1;
              end
            end else if (step_q == 2'd1 && !going_down_q) begin
              if (!below && under && cur_thr_q != tt) begin
                cur_thr_d = pctds_pkg::clamp_thr(thr_up, tt);
              end else if (start_thr_q > ThrW'(1)) begin
                going_down_d = 1'b1;
                cur_thr_d    = pctds_pkg::clamp_thr({1'b0, start_thr_q} - (ThrW+1)'(1), tt);
              end else begin
                do_leave0 = 1'b1;
              end
            end else if (going_down_q) begin
              if (below || cur_thr_q == ThrW'(1)) begin
                do_leave0 = 1'b1;
              end else begin
                cur_thr_d = pctds_pkg::clamp_thr(thr_dn, tt);
              end
            end else begin
              if (over || cur_thr_q == tt || below) begin
                if (start_thr_q > ThrW'(1)) begin
                  going_down_d = 1'b1;
                  cur_thr_d    = pctds_pkg::clamp_thr({1'b0, start_thr_q} - (ThrW+1)'(1), tt);
                end else begin
                  do_leave0 = 1'b1;
                end
              end else begin
                cur_thr_d = pctds_pkg::clamp_thr(thr_up, tt);
              end
            end
          end
          pctds_pkg::PH_FASTER: begin
            if ((under && cur_pst_q == '0) || (over && cur_thr_q == ThrW'(1))) begin
              do_leave1 = 1'b1;
            end else if (under) begin
              cur_pst_d = pctds_pkg::clamp_pst({1'b0, cur_pst_q} - (PstW+1)'(1), sp);
            end else begin
              cur_thr_d = pctds_pkg::clamp_thr(thr_dn, tt);
            end
          end
          default: begin
            // slower p-states, adding threads at each level
            if ((cur_pst_q == sp && over) || (cur_pst_q == sp && cur_thr_q == tt) ||
                tput_q < level_tput_q || (cur_thr_q == tt && under)) begin
              do_finish = 1'b1;
            end else if (under) begin
              if (tput_q > level_tput_q) level_tput_d = tput_q;
              cur_thr_d = pctds_pkg::clamp_thr(thr_up, tt);
            end else begin
              cur_pst_d    = pctds_pkg::clamp_pst({1'b0, cur_pst_q} + (PstW+1)'(1), sp);
              level_tput_d = '0;
            end
          end
        endcase

        // leaving thread tuning: p-state is still the applied one here
        if (do_leave0) begin
          p0_thr_d = best_pos ? best_thr_d : ThrW'(1);
          p0_pst_d = cur_pst_q;
          if (cur_pst_q == '0) begin
            if (best_vld_d && best_thr_d == tt) begin
              do_finish = 1'b1;
            end else begin
              phase_d = pctds_pkg::PH_SLOWER;
              if (best_pos) begin
                cur_thr_d = pctds_pkg::clamp_thr({1'b0, best_thr_d}, tt);
                cur_pst_d = pctds_pkg::clamp_pst({1'b0, cur_pst_q} + (PstW+1)'(1), sp);
              end
              level_tput_d = '0;
            end
          end else begin
            phase_d = pctds_pkg::PH_FASTER;
            if (best_pos) begin
              cur_thr_d = pctds_pkg::clamp_thr({1'b0, best_thr_d}, tt);
              cur_pst_d = pctds_pkg::clamp_pst({1'b0, cur_pst_q} - (PstW+1)'(1), sp);
            end
          end
        end

        // leaving the faster p-state walk
        if (do_leave1) begin
          if (p0_pst_q == sp || (best_vld_d && best_thr_d == tt) || p0_thr_q == tt) begin
            do_finish = 1'b1;
          end else begin
            phase_d = pctds_pkg::PH_SLOWER;
            if (p0_thr_q != '0) begin
              cur_thr_d = pctds_pkg::clamp_thr({1'b0, p0_thr_q}, tt);
              cur_pst_d = pctds_pkg::clamp_pst({1'b0, p0_pst_q} + (PstW+1)'(1), sp);
            end
            level_tput_d = '0;
          end
        end

        if (do_finish) begin
          // apply the best, or one thread at the slowest p-state
          going_down_d = 1'b0;
          stopped_d    = 1'b1;
          level_tput_d = '0;
          p0_thr_d     = '0;
          p0_pst_d     = '0;
          phase_d      = pctds_pkg::PH_TUNE;
          if (!best_vld_d) begin
            best_thr_d = ThrW'(1);
            best_pst_d = sp;
          end
          cur_pst_d = pctds_pkg::clamp_pst({1'b0, best_pst_d}, sp);
          cur_thr_d = pctds_pkg::clamp_thr({1'b0, best_thr_d}, tt);
          step_d    = '0;
        end else if (step_q < pctds_pkg::StepSat) begin
          step_d = step_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= pctds_pkg::PH_TUNE;
      step_q       <= '0;
      going_down_q <= 1'b0;
      stopped_q    <= 1'b0;
      cur_thr_q    <= pctds_pkg::StartThreadsRst;
      cur_pst_q    <= pctds_pkg::StartPstateRst;
      best_vld_q   <= 1'b0;
      best_tput_q  <= '0;
      best_thr_q   <= '0;
      best_pst_q   <= '0;
      level_tput_q <= '0;
      p0_thr_q     <= '0;
      p0_pst_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      step_q       <= step_d;
      going_down_q <= going_down_d;
      stopped_q    <= stopped_d;
      cur_thr_q    <= cur_thr_d;
      cur_pst_q    <= cur_pst_d;
      best_vld_q   <= best_vld_d;
      best_tput_q  <= best_tput_d;
      best_thr_q   <= best_thr_d;
      best_pst_q   <= best_pst_d;
      level_tput_q <= level_tput_d;
      p0_thr_q     <= p0_thr_d;
      p0_pst_q     <= p0_pst_d;
    end
  end

  // the search state after each step is the result item
  assign out_valid_o    = out_vld_q;
  assign next_threads_o = cur_thr_q;
  assign next_pstate_o  = cur_pst_q;
  assign search_done_o  = stopped_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `include "power_cap_thread_dvfs_search_top_assert.svh"

  // a stopped search sits parked in thread tuning with its counters cleared
  `PCTDS_ASSERT(a_done_parked, !stopped_q || (phase_q == pctds_pkg::PH_TUNE && step_q == '0 && !going_down_q))
  // search state only moves when an item is processed
  `PCTDS_ASSERT_NEXT(a_state_hold, !advance, $stable(cur_thr_q) && $stable(cur_pst_q) && $stable(stopped_q))
  // every processed item leaves a result behind
  `PCTDS_ASSERT_NEXT(a_result_follows, advance, out_vld_q)
  // applied thread count is never zero
  `PCTDS_ASSERT(a_thr_nonzero, cur_thr_q != '0)

endmodule
